FILE: sv/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types and constants for the concatenated block remainder engine.
// ----------------------------------------------------------------------------
package cbm_pkg;

  localparam int unsigned INDEX_BITS = 32;
  localparam int unsigned FIELD_MOD_BITS = 63;
  localparam int unsigned VALUE_BITS = 63;   // block members, below 2^63
  localparam int unsigned POW_BITS = 64;     // powers of ten up to 10^19
  localparam int unsigned MUL_B_BITS = 64;   // multiplier bit operand
  localparam int unsigned MUL_CNT_BITS = 6;  // counts MUL_B_BITS steps

  // Multiplications issued by the controller
  typedef enum logic [2:0] {
    OP_Q  = 3'd0,  // 10^d mod m
    OP_A  = 3'd1,  // F.a * S.a
    OP_B  = 3'd2,  // F.a * S.b
    OP_C  = 3'd3,  // F.a * S.c
    OP_K  = 3'd4,  // F.b * S.k
    OP_XA = 3'd5,  // acc.a * x
    OP_XB = 3'd6   // acc.b * cur
  } mul_op_t;

  typedef struct packed {
    logic    load;
    logic    setup;
    logic    set_hi;
    logic    grow;
    logic    run_init;
    logic    mul_start;
    mul_op_t op;
    logic    tgt_acc;
    logic    commit;
    logic    shift;
    logic    finish;
    logic    zero;
  } cbm_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic degenerate;
    logic cur_ge_p10;
    logic len_zero;
    logic len_odd;
    logic len_gt1;
    logic last_run;
  } cbm_stat_t;

endpackage

FILE: sv/cbm_ifs.sv
// ----------------------------------------------------------------------------
// cbm channel interfaces
// Valid/ready channels for block requests and remainders.
// ----------------------------------------------------------------------------
interface cbm_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] block_index;
  logic [62:0] modulus;

  modport source (output valid, block_index, modulus, input ready);
  modport sink (input valid, block_index, modulus, output ready);
endinterface

interface cbm_out_if;
  logic        valid;
  logic        ready;
  logic [62:0] remainder;

  modport source (output valid, remainder, input ready);
  modport sink (input valid, remainder, output ready);
endinterface

FILE: sv/cbm_mulmod.sv
// ----------------------------------------------------------------------------
// cbm_mulmod
// Bit-serial modular multiplier: one bit of the b operand per cycle, MSB first.
// ----------------------------------------------------------------------------
module cbm_mulmod #(
  parameter int unsigned W = 63
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [W-1:0]                   a,
  input  logic [cbm_pkg::MUL_B_BITS-1:0] b,
  input  logic [W-1:0]                   m,
  output logic [W-1:0]                   prod,
  output logic                           done
);
  import cbm_pkg::*;

  logic [W-1:0]            r;
  logic [MUL_B_BITS-1:0]   bsh;
  logic [MUL_CNT_BITS-1:0] cnt;
  logic                    busy;
  logic [W:0]              dbl;
  logic [W:0]              dbl_red;
  logic [W:0]              sum;
  logic [W-1:0]            r_next;

  always_comb begin
    dbl = {r, 1'b0};
    dbl_red = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
    sum = bsh[MUL_B_BITS-1] ? dbl_red + {1'b0, a} : dbl_red;
    r_next = (sum >= {1'b0, m}) ? W'(sum - {1'b0, m}) : W'(sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        r <= '0;
        bsh <= b;
      end else if (busy) begin
        r <= r_next;
        bsh <= bsh << 1;
        cnt <= cnt + 1'b1;
        if (cnt == '1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod = r;

endmodule

FILE: sv/cbm_datapath.sv
// ----------------------------------------------------------------------------
// cbm_datapath
// Run bounds, affine map registers, running remainder and the shared multiplier.
// ----------------------------------------------------------------------------
module cbm_datapath #(
  parameter int unsigned W = 63
) (
  input  logic                               clk,
  input  logic                               rst,
  input  cbm_pkg::cbm_cmd_t                  cmd,
  input  logic [cbm_pkg::INDEX_BITS-1:0]     block_index,
  input  logic [cbm_pkg::FIELD_MOD_BITS-1:0] modulus,
  output cbm_pkg::cbm_stat_t                 stat,
  output logic [cbm_pkg::FIELD_MOD_BITS-1:0] remainder
);
  import cbm_pkg::*;

  logic [INDEX_BITS-1:0] n;
  logic [W-1:0]          m;
  logic [VALUE_BITS-1:0] cur;
  logic [VALUE_BITS-1:0] hi;
  logic [VALUE_BITS-1:0] endv;
  logic [POW_BITS-1:0]   p10;
  logic [INDEX_BITS-1:0] len;
  logic [W-1:0]          x;
  logic [W-1:0]          acc_a, acc_b, acc_c, acc_k;
  logic [W-1:0]          sq_a, sq_b, sq_c, sq_k;
  logic [W-1:0]          na, nb, nc;

  logic [W-1:0]            mul_a;
  logic [MUL_B_BITS-1:0]   mul_b;
  logic [W-1:0]            prod;
  logic                    mul_done;
  logic [VALUE_BITS-1:0]   endv_c;
  logic [2*INDEX_BITS-1:0] tri2;
  logic [W-1:0]            s_a, s_b, s_c, s_k;

  function automatic logic [W-1:0] addm(input logic [W-1:0] p, input logic [W-1:0] q,
                                        input logic [W-1:0] md);
    logic [W:0] s;
    s = {1'b0, p} + {1'b0, q};
    if (s >= {1'b0, md}) s = s - {1'b0, md};
    return s[W-1:0];
  endfunction

  // Target map S of a chain: acc or sq
  always_comb begin
    s_a = cmd.tgt_acc ? acc_a : sq_a;
    s_b = cmd.tgt_acc ? acc_b : sq_b;
    s_c = cmd.tgt_acc ? acc_c : sq_c;
    s_k = cmd.tgt_acc ? acc_k : sq_k;
  end

  always_comb begin
    case (cmd.op)
      OP_Q: begin
        mul_a = W'(1);
        mul_b = p10;
      end
      OP_A: begin
        mul_a = sq_a;
        mul_b = MUL_B_BITS'(s_a);
      end
      OP_B: begin
        mul_a = sq_a;
        mul_b = MUL_B_BITS'(s_b);
      end
      OP_C: begin
        mul_a = sq_a;
        mul_b = MUL_B_BITS'(s_c);
      end
      OP_K: begin
        mul_a = sq_b;
        mul_b = MUL_B_BITS'(s_k);
      end
      OP_XA: begin
        mul_a = acc_a;
        mul_b = MUL_B_BITS'(x);
      end
      OP_XB: begin
        mul_a = acc_b;
        mul_b = MUL_B_BITS'(cur);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  cbm_mulmod #(.W(W)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .m     (m),
    .prod  (prod),
    .done  (mul_done)
  );

  assign tri2 = n * (n - 1'b1);
  assign endv_c = ({1'b0, hi} < p10 - 1'b1) ? hi : VALUE_BITS'(p10 - 1'b1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n <= block_index;
      m <= modulus[W-1:0];
    end
    if (cmd.setup) cur <= VALUE_BITS'(tri2 >> 1) + 1'b1;
    if (cmd.set_hi) begin
      hi <= cur + VALUE_BITS'(n) - 1'b1;
      p10 <= POW_BITS'(10);
      x <= '0;
    end
    if (cmd.grow) p10 <= (p10 << 3) + (p10 << 1);
    if (cmd.run_init) begin
      endv <= endv_c;
      len <= INDEX_BITS'(endv_c - cur + 1'b1);
      acc_a <= W'(1);
      acc_b <= '0;
      acc_c <= '0;
      acc_k <= '0;
      sq_b <= W'(1);
      sq_c <= '0;
      sq_k <= W'(1);
    end
    if (mul_done) begin
      case (cmd.op)
        OP_Q:  sq_a <= prod;
        OP_A:  na <= prod;
        OP_B:  nb <= addm(prod, sq_b, m);
        OP_C:  nc <= addm(prod, sq_c, m);
        OP_K:  nc <= addm(nc, prod, m);
        OP_XA: na <= prod;
        OP_XB: na <= addm(na, prod, m);
        default: na <= na;
      endcase
    end
    if (cmd.commit) begin
      if (cmd.tgt_acc) begin
        acc_a <= na;
        acc_b <= nb;
        acc_c <= nc;
        acc_k <= addm(acc_k, sq_k, m);
      end else begin
        sq_a <= na;
        sq_b <= nb;
        sq_c <= nc;
        sq_k <= addm(sq_k, sq_k, m);
      end
    end
    if (cmd.shift) len <= len >> 1;
    if (cmd.finish) begin
      x <= addm(na, acc_c, m);
      cur <= endv + 1'b1;
    end
    if (cmd.zero) x <= '0;
  end

  always_comb begin
    stat.mul_done = mul_done;
    stat.degenerate = (m <= W'(1)) || (n == '0);
    stat.cur_ge_p10 = {1'b0, cur} >= p10;
    stat.len_zero = (len == '0);
    stat.len_odd = len[0];
    stat.len_gt1 = (len > INDEX_BITS'(1));
    stat.last_run = (endv == hi);
  end

  assign remainder = FIELD_MOD_BITS'(x);

endmodule

FILE: sv/cbm_ctrl.sv
// ----------------------------------------------------------------------------
// cbm_ctrl
// Sequencer: run split, square-and-multiply over affine maps, handshakes.
// ----------------------------------------------------------------------------
module cbm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  cbm_pkg::cbm_stat_t stat,
  output cbm_pkg::cbm_cmd_t  cmd
);
  import cbm_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_SETUP  = 12'b0000_0000_0010,
    S_SETHI  = 12'b0000_0000_0100,
    S_DIG    = 12'b0000_0000_1000,
    S_RUNSET = 12'b0000_0001_0000,
    S_MUL    = 12'b0000_0010_0000,
    S_MWAIT  = 12'b0000_0100_0000,
    S_LOOP   = 12'b0000_1000_0000,
    S_COMMIT = 12'b0001_0000_0000,
    S_SHIFT  = 12'b0010_0000_0000,
    S_FIN    = 12'b0100_0000_0000,
    S_OUT    = 12'b1000_0000_0000
  } state_t;

  state_t  state, state_next;
  mul_op_t op, op_next;
  logic    tgt_acc, tgt_acc_next;

  always_comb begin
    state_next = state;
    op_next = op;
    tgt_acc_next = tgt_acc;
    cmd = '0;
    cmd.op = op;
    cmd.tgt_acc = tgt_acc;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        if (stat.degenerate) begin
          cmd.zero = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.setup = 1'b1;
          state_next = S_SETHI;
        end
      end
      S_SETHI: begin
        cmd.set_hi = 1'b1;
        state_next = S_DIG;
      end
      S_DIG: begin
        // grow 10^d until it exceeds the current member
        if (stat.cur_ge_p10) cmd.grow = 1'b1;
        else state_next = S_RUNSET;
      end
      S_RUNSET: begin
        cmd.run_init = 1'b1;
        op_next = OP_Q;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul_start = 1'b1;
        state_next = S_MWAIT;
      end
      S_MWAIT: begin
        if (stat.mul_done) begin
          case (op)
            OP_Q: state_next = S_LOOP;
            OP_A: begin
              op_next = OP_B;
              state_next = S_MUL;
            end
            OP_B: begin
              op_next = OP_C;
              state_next = S_MUL;
            end
            OP_C: begin
              op_next = OP_K;
              state_next = S_MUL;
            end
            OP_K: state_next = S_COMMIT;
            OP_XA: begin
              op_next = OP_XB;
              state_next = S_MUL;
            end
            OP_XB: state_next = S_FIN;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_LOOP: begin
        if (stat.len_zero) begin
          op_next = OP_XA;
          state_next = S_MUL;
        end else if (stat.len_odd) begin
          tgt_acc_next = 1'b1;
          op_next = OP_A;
          state_next = S_MUL;
        end else begin
          state_next = S_SHIFT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = tgt_acc ? S_SHIFT : S_LOOP;
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (stat.len_gt1) begin
          // square only while exponent bits remain
          tgt_acc_next = 1'b0;
          op_next = OP_A;
          state_next = S_MUL;
        end else begin
          state_next = S_LOOP;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = stat.last_run ? S_OUT : S_DIG;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op <= OP_Q;
      tgt_acc <= 1'b0;
    end else begin
      state <= state_next;
      op <= op_next;
      tgt_acc <= tgt_acc_next;
    end
  end

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

endmodule

FILE: sv/concat_block_mod.sv
// ----------------------------------------------------------------------------
// concat_block_mod
// Remainder of the decimal concatenation of one triangular block of integers.
// ----------------------------------------------------------------------------
// For block index n the block holds n(n-1)/2+1 .. n(n+1)/2; the result is that
// digit string read as a number, modulo the modulus (0 for modulus 0 or 1, or
// n = 0). One beat is worked at a time. All modular products go through one
// bit-serial multiplier; each run of equal digit count follows a digit search
// and is worked by square-and-multiply over the bits of its length; a block
// has one or two runs.
module concat_block_mod #(
  parameter int unsigned MODULUS_BITS = 63
) (
  input logic       clk,
  input logic       rst,
  cbm_in_if.sink    in_ch,
  cbm_out_if.source out_ch
);
  import cbm_pkg::*;

  cbm_cmd_t  cmd;
  cbm_stat_t stat;

  cbm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cbm_datapath #(.W(MODULUS_BITS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .block_index (in_ch.block_index),
    .modulus     (in_ch.modulus),
    .stat        (stat),
    .remainder   (out_ch.remainder)
  );

endmodule
